FILE: rtl/clq_pkg.sv
package clq_pkg;

    // Size of the element pool and the widths that follow from it.
    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Fixed field widths of the request and response.
    localparam int ELEM_W = 6;
    localparam int LEN_W  = 7;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic
    {
        OP_APPEND = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK     = 2'd0,
        STATUS_LINKED = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_ABSENT = 2'd3
    } status_t;

    typedef struct packed
    {
        op_t                operation;
        logic [ELEM_W-1:0]  element;
    } req_t;

    typedef struct packed
    {
        status_t            status;
        logic [ELEM_W-1:0]  head_element;
        logic               queue_empty;
        logic [LEN_W-1:0]   queue_length;
    } rsp_t;

    // Access to one link memory in one cycle: one read and one write.
    typedef struct packed
    {
        logic   re;
        slot_t  raddr;
        logic   we;
        slot_t  waddr;
        slot_t  wdata;
    } ram_cmd_t;

endpackage

FILE: rtl/clq_link_ram.sv
module clq_link_ram
(
    input  logic               clk,
    input  clq_pkg::ram_cmd_t  cmd,
    output clq_pkg::slot_t     rdata
);

    clq_pkg::slot_t mem [clq_pkg::SLOTS];
    clq_pkg::slot_t rdata_reg;

    // Synchronous write port.
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
    end

    // Synchronous read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rdata_reg <= mem[cmd.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/clq_ctrl.sv
module clq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_ready,
    input  clq_pkg::req_t      request,
    output logic               response_valid,
    input  logic               response_ready,
    output clq_pkg::rsp_t      response,
    output clq_pkg::ram_cmd_t  next_cmd,
    input  clq_pkg::slot_t     next_rdata,
    output clq_pkg::ram_cmd_t  prev_cmd,
    input  clq_pkg::slot_t     prev_rdata
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_APPEND1,
        S_APPEND2,
        S_REMOVE,
        S_PUSH
    } state_t;

    state_t                      state_reg, state_next;
    clq_pkg::slot_t              elem_reg, elem_next;
    clq_pkg::slot_t              tail_reg, tail_next;
    clq_pkg::slot_t              head_reg, head_next;
    logic                        empty_reg, empty_next;
    clq_pkg::count_t             count_reg, count_next;
    logic [clq_pkg::SLOTS-1:0]   flags_reg, flags_next;
    clq_pkg::rsp_t               res_reg, res_next;
    logic                        out_valid_reg, out_valid_next;
    clq_pkg::rsp_t               out_reg, out_next;

    logic                        accept;
    logic                        in_range;
    clq_pkg::slot_t              idx_in;
    clq_pkg::status_t            status_next;

    assign request_ready  = (state_reg == S_IDLE);
    assign accept         = request_valid && request_ready;
    assign idx_in         = clq_pkg::SLOT_W'(request.element);
    assign in_range       = (32'(request.element) < 32'(clq_pkg::SLOTS));
    assign response_valid = out_valid_reg;
    assign response       = out_reg;

    // Sequencer: check flags and start the link reads on acceptance, then rewrite the links unless the request fails.
    always_comb
    begin
        state_next  = state_reg;
        elem_next   = elem_reg;
        tail_next   = tail_reg;
        head_next   = head_reg;
        empty_next  = empty_reg;
        count_next  = count_reg;
        flags_next  = flags_reg;
        status_next = clq_pkg::STATUS_OK;
        next_cmd    = '0;
        prev_cmd    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    elem_next      = idx_in;
                    // Remove needs both links of the element; append needs the tail.
                    next_cmd.re    = 1'b1;
                    next_cmd.raddr = idx_in;
                    prev_cmd.re    = 1'b1;
                    prev_cmd.raddr = (request.operation == clq_pkg::OP_APPEND) ?
                                     head_reg : idx_in;
                    if (request.operation == clq_pkg::OP_APPEND)
                    begin
                        if (!in_range)
                        begin
                            status_next = clq_pkg::STATUS_ABSENT;
                            state_next  = S_PUSH;
                        end
                        else if (flags_reg[idx_in])
                        begin
                            status_next = clq_pkg::STATUS_LINKED;
                            state_next  = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_APPEND1;
                        end
                    end
                    else
                    begin
                        if (empty_reg)
                        begin
                            status_next = clq_pkg::STATUS_EMPTY;
                            state_next  = S_PUSH;
                        end
                        else if (!in_range || !flags_reg[idx_in])
                        begin
                            status_next = clq_pkg::STATUS_ABSENT;
                            state_next  = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_REMOVE;
                        end
                    end
                end
            end

            S_APPEND1:
            begin
                next_cmd.we    = 1'b1;
                next_cmd.waddr = elem_reg;
                prev_cmd.we    = 1'b1;
                prev_cmd.waddr = elem_reg;
                if (empty_reg)
                begin
                    // First element links to itself and becomes the head.
                    next_cmd.wdata       = elem_reg;
                    prev_cmd.wdata       = elem_reg;
                    head_next            = elem_reg;
                    empty_next           = 1'b0;
                    flags_next[elem_reg] = 1'b1;
                    count_next           = count_reg + clq_pkg::CNT_W'(1);
                    state_next           = S_PUSH;
                end
                else
                begin
                    // The new element sits between the old tail and the head.
                    tail_next      = prev_rdata;
                    next_cmd.wdata = head_reg;
                    prev_cmd.wdata = prev_rdata;
                    state_next     = S_APPEND2;
                end
            end

            S_APPEND2:
            begin
                next_cmd.we          = 1'b1;
                next_cmd.waddr       = tail_reg;
                next_cmd.wdata       = elem_reg;
                prev_cmd.we          = 1'b1;
                prev_cmd.waddr       = head_reg;
                prev_cmd.wdata       = elem_reg;
                flags_next[elem_reg] = 1'b1;
                count_next           = count_reg + clq_pkg::CNT_W'(1);
                state_next           = S_PUSH;
            end

            S_REMOVE:
            begin
                // Join the neighbours of the element to each other.
                prev_cmd.we    = 1'b1;
                prev_cmd.waddr = next_rdata;
                prev_cmd.wdata = prev_rdata;
                next_cmd.we    = 1'b1;
                next_cmd.waddr = prev_rdata;
                next_cmd.wdata = next_rdata;
                if (elem_reg == head_reg)
                begin
                    if (next_rdata == elem_reg)
                    begin
                        empty_next = 1'b1;
                        head_next  = '0;
                    end
                    else
                    begin
                        head_next = next_rdata;
                    end
                end
                flags_next[elem_reg] = 1'b0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - clq_pkg::CNT_W'(1);
                end
                state_next = S_PUSH;
            end

            S_PUSH:
            begin
                if (!out_valid_reg || response_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result as seen after this cycle's updates.
    always_comb
    begin
        res_next              = res_reg;
        res_next.status       = status_next;
        res_next.head_element = empty_next ? '0 : clq_pkg::ELEM_W'(head_next);
        res_next.queue_empty  = empty_next;
        res_next.queue_length = clq_pkg::LEN_W'(count_next);
    end

    // Output register: loaded from the pending result when the slot is free.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && response_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_PUSH && (!out_valid_reg || response_ready))
        begin
            out_valid_next = 1'b1;
            out_next       = res_reg;
        end
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            empty_reg     <= 1'b1;
            count_reg     <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            count_reg     <= count_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        tail_reg <= tail_next;
        out_reg  <= out_next;
        if (state_next == S_PUSH && state_reg != S_PUSH)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/circular_linked_queue_manager.sv
// Channel    Direction  Handshake                        Payload
// request    in         request_valid / request_ready    clq_pkg::req_t
// response   out        response_valid / response_ready  clq_pkg::rsp_t
//
// One request is processed at a time, taken only while the sequencer is
// idle. Errors go from idle straight to push; a remove passes S_REMOVE and
// an append S_APPEND1 and S_APPEND2 (only S_APPEND1 on an empty queue), as
// each link memory has a registered read and one write port. A finished
// response waits in the output register; the next request is taken while
// it waits. Reset empties the queue at once; link memories are not cleared.
module circular_linked_queue_manager
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           request_valid,
    output logic           request_ready,
    input  clq_pkg::req_t  request,
    output logic           response_valid,
    input  logic           response_ready,
    output clq_pkg::rsp_t  response
);

    clq_pkg::ram_cmd_t next_cmd;
    clq_pkg::ram_cmd_t prev_cmd;
    clq_pkg::slot_t    next_rdata;
    clq_pkg::slot_t    prev_rdata;

    // Sequencer, flags and output register.
    clq_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_ready  (request_ready),
        .request        (request),
        .response_valid (response_valid),
        .response_ready (response_ready),
        .response       (response),
        .next_cmd       (next_cmd),
        .next_rdata     (next_rdata),
        .prev_cmd       (prev_cmd),
        .prev_rdata     (prev_rdata)
    );

    // Successor links.
    clq_link_ram u_next_ram
    (
        .clk   (clk),
        .cmd   (next_cmd),
        .rdata (next_rdata)
    );

    // Predecessor links.
    clq_link_ram u_prev_ram
    (
        .clk   (clk),
        .cmd   (prev_cmd),
        .rdata (prev_rdata)
    );

endmodule

FILE: rtl/clq_checker.sv
module clq_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           request_valid,
    input  logic           request_ready,
    input  clq_pkg::req_t  request,
    input  logic           response_valid,
    input  logic           response_ready,
    input  clq_pkg::rsp_t  response
);

    // A stalled response holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        response_valid && !response_ready |=> response_valid && $stable(response))
        else $error("response changed while stalled");

    // Only one request is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && request_ready |=> !request_ready)
        else $error("request taken while another is in work");

    // The empty flag agrees with the length.
    assert property (@(posedge clk) disable iff (!rst_n)
        response_valid |-> (response.queue_empty == (response.queue_length == '0)))
        else $error("empty flag and length disagree");

    // An empty queue reports head zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        response_valid && response.queue_empty |-> response.head_element == '0)
        else $error("head not zero on an empty queue");

endmodule

bind circular_linked_queue_manager clq_checker u_checker (.*);

FILE: sim/circular_linked_queue_manager_tb.sv
module circular_linked_queue_manager_tb;

    import clq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 900;
    localparam int IDLE_PERCENT = 22;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;

    logic   clk;
    logic   rst_n          = 1'b0;
    logic   request_valid  = 1'b0;
    logic   request_ready;
    req_t   request        = '0;
    logic   response_valid;
    logic   response_ready = 1'b0;
    rsp_t   response;

    circular_linked_queue_manager dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_ready  (request_ready),
        .request        (request),
        .response_valid (response_valid),
        .response_ready (response_ready),
        .response       (response)
    );

    // Shadow copy of the queue: links, membership, head, empty flag and size.
    slot_t       succ_of [SLOTS];
    slot_t       pred_of [SLOTS];
    bit          in_queue [SLOTS];
    slot_t       head_slot;
    bit          is_empty;
    int unsigned shadow_len;

    // Responses still owed by the block, oldest first.
    rsp_t        awaited_responses [$];

    int          mismatches;
    int          cycle_count;
    int unsigned appends_done;
    int unsigned removes_done;
    int unsigned status_seen [4];
    int unsigned peak_size;

    // Shared between the sender and the receiver.
    bit          quiet;
    bit          hold_request;

    typedef struct
    {
        req_t   req;
        bit     typed;
        rsp_t   rsp;
    } plan_row_t;

    plan_row_t   plan [$];

    // Applies one operation to the shadow queue and returns the response it calls for.
    function automatic rsp_t queue_apply(req_t r);
        rsp_t    res;
        status_t st;
        int      e;
        slot_t   tail;
        slot_t   nx;
        slot_t   pv;
        e = int'(r.element);
        st = STATUS_OK;
        if (r.operation == OP_APPEND)
        begin
            appends_done++;
            if (e >= SLOTS)
                st = STATUS_ABSENT;
            else if (in_queue[e])
                st = STATUS_LINKED;
            else
            begin
                if (is_empty)
                begin
                    head_slot = slot_t'(e);
                    succ_of[e] = slot_t'(e);
                    pred_of[e] = slot_t'(e);
                    is_empty = 1'b0;
                end
                else
                begin
                    tail = pred_of[head_slot];
                    succ_of[e] = head_slot;
                    pred_of[e] = tail;
                    succ_of[tail] = slot_t'(e);
                    pred_of[head_slot] = slot_t'(e);
                end
                in_queue[e] = 1'b1;
                shadow_len++;
            end
        end
        else
        begin
            removes_done++;
            if (is_empty)
                st = STATUS_EMPTY;
            else if (e >= SLOTS || !in_queue[e])
                st = STATUS_ABSENT;
            else
            begin
                nx = succ_of[e];
                pv = pred_of[e];
                if (slot_t'(e) == head_slot)
                begin
                    if (nx == slot_t'(e))
                    begin
                        is_empty = 1'b1;
                        head_slot = '0;
                    end
                    else
                        head_slot = nx;
                end
                pred_of[nx] = pv;
                succ_of[pv] = nx;
                in_queue[e] = 1'b0;
                if (shadow_len > 0)
                    shadow_len--;
            end
        end
        status_seen[st]++;
        if (shadow_len > peak_size)
            peak_size = shadow_len;
        res.status       = st;
        res.head_element = is_empty ? '0 : ELEM_W'(head_slot);
        res.queue_empty  = is_empty;
        res.queue_length = LEN_W'(shadow_len);
        return res;
    endfunction

    // Picks a slot whose membership matches the wish, starting at a random place.
    function automatic int pick_slot(bit want_linked);
        int s;
        s = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
        begin
            if (in_queue[(s + k) % SLOTS] == want_linked)
                return (s + k) % SLOTS;
        end
        return s;
    endfunction

    function automatic plan_row_t plan_row(op_t op, int elem, bit typed, status_t st,
                                           int hd, bit emp, int len);
        plan_row_t row;
        row.req.operation    = op;
        row.req.element      = ELEM_W'(elem);
        row.typed            = typed;
        row.rsp.status       = st;
        row.rsp.head_element = ELEM_W'(hd);
        row.rsp.queue_empty  = emp;
        row.rsp.queue_length = LEN_W'(len);
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0d] mismatch: %s got %0d, expected %0d", cycle_count, what, got, want);
    endtask

    // Offers one request, holding it until the transfer, then records what it must produce.
    task automatic send_request(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t predicted;
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            request_valid <= 1'b0;
            @(posedge clk);
        end
        request_valid <= 1'b1;
        request       <= r;
        @(posedge clk);
        while (!request_ready)
            @(posedge clk);
        predicted = queue_apply(r);
        awaited_responses.push_back(typed ? typed_rsp : predicted);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Guard against a hang.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("circular_linked_queue_manager regression: fail");
        $finish;
    end

    // Receiver: checks each transfer and decides the ready for the next cycle.
    initial
    begin
        int   hold_left;
        rsp_t want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && response_valid && response_ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    flag_mismatch("responses awaited", 0, 1);
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (response.status !== want.status)
                        flag_mismatch("status", response.status, want.status);
                    if (response.head_element !== want.head_element)
                        flag_mismatch("head_element", response.head_element, want.head_element);
                    if (response.queue_empty !== want.queue_empty)
                        flag_mismatch("queue_empty", response.queue_empty, want.queue_empty);
                    if (response.queue_length !== want.queue_length)
                        flag_mismatch("queue_length", response.queue_length, want.queue_length);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                response_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                response_ready <= 1'b0;
            end
            else
                response_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Sender: reset, the directed plan, the random part, then the drain.
    initial
    begin
        req_t r;
        bit   filling;
        int   roll;
        mismatches   = 0;
        appends_done = 0;
        removes_done = 0;
        peak_size    = 0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            succ_of[i]  = '0;
            pred_of[i]  = '0;
            in_queue[i] = 1'b0;
        end
        head_slot  = '0;
        is_empty   = 1'b1;
        shadow_len = 0;

        // Removes on an empty queue, a repeated append, a remove of a stranger,
        // then removal of the middle, the tail, the head and the last element.
        plan.push_back(plan_row(OP_REMOVE, 0,  1, STATUS_EMPTY,  0,  1, 0));
        plan.push_back(plan_row(OP_REMOVE, 63, 1, STATUS_EMPTY,  0,  1, 0));
        plan.push_back(plan_row(OP_APPEND, 0,  1, STATUS_OK,     0,  0, 1));
        plan.push_back(plan_row(OP_APPEND, 0,  1, STATUS_LINKED, 0,  0, 1));
        plan.push_back(plan_row(OP_APPEND, 63, 1, STATUS_OK,     0,  0, 2));
        plan.push_back(plan_row(OP_REMOVE, 17, 1, STATUS_ABSENT, 0,  0, 2));
        plan.push_back(plan_row(OP_APPEND, 42, 1, STATUS_OK,     0,  0, 3));
        plan.push_back(plan_row(OP_APPEND, 21, 0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_REMOVE, 42, 0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_REMOVE, 21, 0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_REMOVE, 0,  0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_APPEND, 63, 1, STATUS_LINKED, 63, 0, 1));
        plan.push_back(plan_row(OP_REMOVE, 63, 1, STATUS_OK,     0,  1, 0));
        plan.push_back(plan_row(OP_REMOVE, 63, 1, STATUS_EMPTY,  0,  1, 0));
        plan.push_back(plan_row(OP_APPEND, 63, 1, STATUS_OK,     63, 0, 1));
        plan.push_back(plan_row(OP_REMOVE, 0,  1, STATUS_ABSENT, 63, 0, 1));
        plan.push_back(plan_row(OP_APPEND, 5,  0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_APPEND, 10, 0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_REMOVE, 63, 0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_APPEND, 63, 0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_REMOVE, 63, 0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_REMOVE, 10, 0, STATUS_OK,     0,  0, 0));
        plan.push_back(plan_row(OP_REMOVE, 5,  0, STATUS_OK,     0,  0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_request(plan[i].req, plan[i].typed, plan[i].rsp);

        // Random part: swings between filling and draining so the queue
        // reaches both full and empty, with some noise among the requests.
        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 450 && n < 600);
            if (n == 150)
                hold_request = 1'b1;
            if (shadow_len == SLOTS)
                filling = 1'b0;
            else if (shadow_len == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 59) == 0)
                filling = !filling;
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                r.operation = $urandom_range(0, 1) ? OP_REMOVE : OP_APPEND;
                r.element   = ELEM_W'($urandom_range(0, 63));
            end
            else if (filling ? (roll < 80) : (roll < 28))
            begin
                r.operation = OP_APPEND;
                r.element   = ELEM_W'(pick_slot(1'b0));
            end
            else
            begin
                r.operation = OP_REMOVE;
                r.element   = ELEM_W'(pick_slot(1'b1));
            end
            send_request(r, 1'b0, '0);
        end
        quiet = 1'b0;
        request_valid <= 1'b0;

        // Drain what is still owed, then watch for stray responses.
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d appends and %0d removes; peak queue size %0d.",
                 appends_done, removes_done, peak_size);
        $display("Statuses: ok %0d, already linked %0d, empty %0d, not in queue %0d.",
                 status_seen[STATUS_OK], status_seen[STATUS_LINKED],
                 status_seen[STATUS_EMPTY], status_seen[STATUS_ABSENT]);
        if (mismatches == 0)
            $display("circular_linked_queue_manager regression: pass");
        else
            $display("circular_linked_queue_manager regression: fail");
        $finish;
    end

endmodule

FILE: circular_linked_queue_manager.f
rtl/clq_pkg.sv
rtl/clq_link_ram.sv
rtl/clq_ctrl.sv
rtl/circular_linked_queue_manager.sv
rtl/clq_checker.sv
sim/circular_linked_queue_manager_tb.sv
